// File: rtl/core/refcount_table_lazy_sweep_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the refcount table with lazy sweep
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REFCOUNT_TABLE_LAZY_SWEEP_ASSERT_SVH
`define REFCOUNT_TABLE_LAZY_SWEEP_ASSERT_SVH

// same-cycle implication
`define RCT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rct_pkg.sv
// ----------------------------------------------------------------------------
// rct_pkg
// Shared constants, codes and the result record of the refcount table.
// ----------------------------------------------------------------------------
package rct_pkg;

  // default sizing
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned ID_BITS_DEF       = 16;
  localparam int unsigned COUNT_BITS_DEF    = 16;

  // fixed port widths
  localparam int unsigned ID_PORT_W  = 16;
  localparam int unsigned CNT_PORT_W = 16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_INC   = 2'd1,
    OP_DEC   = 2'd2,
    OP_SWEEP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_SATURATED = 3'd5,
    ST_RECLAIMED = 3'd6,
    ST_NOTHING   = 3'd7
  } status_t;

  // one result transaction
  typedef struct packed {
    status_t                 status;
    logic [ID_PORT_W-1:0]    result_id;
    logic [CNT_PORT_W-1:0]   new_count;
    logic                    last;
  } result_t;

endpackage

// File: rtl/core/rct_ram.sv
// ----------------------------------------------------------------------------
// rct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rct_ram
  import rct_pkg::*;
#(
  parameter int unsigned WIDTH = ID_BITS_DEF + COUNT_BITS_DEF,
  parameter int unsigned DEPTH = TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/rct_ctrl.sv
// ----------------------------------------------------------------------------
// rct_ctrl
// Sequencer: serial id scan over the entry RAM, read-modify-write of the
// hit entry, sweep of marked entries, and the result register.
// ----------------------------------------------------------------------------
module rct_ctrl
  import rct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned ID_BITS       = ID_BITS_DEF,
  parameter int unsigned COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [1:0]                        in_opcode,
  input  logic [ID_PORT_W-1:0]              in_object_id,
  output logic                              busy,
  output logic                              out_strobe,
  output result_t                           out_res,
  output logic                              ram_we,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  ram_waddr,
  output logic [ID_BITS+COUNT_BITS-1:0]     ram_wdata,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  ram_raddr,
  input  logic [ID_BITS+COUNT_BITS-1:0]     ram_rdata
);

  localparam int unsigned IdxW    = $clog2(TABLE_ENTRIES);
  localparam int unsigned IdExtW  = (ID_BITS > ID_PORT_W) ? ID_BITS : ID_PORT_W;
  localparam int unsigned CntExtW = (COUNT_BITS > CNT_PORT_W) ? COUNT_BITS : CNT_PORT_W;
  localparam logic [IdxW-1:0]       LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] CntMax  = '1;
  localparam logic [COUNT_BITS-1:0] CntOne  = COUNT_BITS'(1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  // width adapters between table fields and fixed-width ports
  function automatic logic [ID_PORT_W-1:0] id_to_port(input logic [ID_BITS-1:0] v);
    logic [IdExtW-1:0] e;
    e = IdExtW'(v);
    return e[ID_PORT_W-1:0];
  endfunction

  function automatic logic [CNT_PORT_W-1:0] cnt_to_port(input logic [COUNT_BITS-1:0] v);
    logic [CntExtW-1:0] e;
    e = CntExtW'(v);
    return e[CNT_PORT_W-1:0];
  endfunction

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [ID_BITS-1:0]      id_r, id_nxt;
  logic [IdxW-1:0]         issue_idx_r, issue_idx_nxt;
  logic [IdxW-1:0]         data_idx_r, data_idx_nxt;
  logic                    data_vld_r, data_vld_nxt;
  logic                    hit_r, hit_nxt;
  logic [IdxW-1:0]         hit_idx_r, hit_idx_nxt;
  logic [COUNT_BITS-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic                    free_ok_r, free_ok_nxt;
  logic [IdxW-1:0]         free_idx_r, free_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [TABLE_ENTRIES-1:0] marked_r, marked_nxt;
  logic [TABLE_ENTRIES-1:0] sweep_vec_r, sweep_vec_nxt;
  logic                    out_vld_r, out_vld_nxt;
  result_t                 out_res_r, out_res_nxt;

  logic [IdExtW-1:0]        in_id_ext;
  logic [ID_BITS-1:0]       rd_id;
  logic [COUNT_BITS-1:0]    rd_cnt;
  logic [TABLE_ENTRIES-1:0] onehot;
  logic [TABLE_ENTRIES-1:0] sweep_rest;
  logic [COUNT_BITS-1:0]    cnt_dec;

  assign in_id_ext = IdExtW'(in_object_id);
  assign rd_id     = ram_rdata[ID_BITS-1:0];
  assign rd_cnt    = ram_rdata[ID_BITS+COUNT_BITS-1:ID_BITS];
  assign cnt_dec   = hit_cnt_r - 1'b1;
  assign ram_raddr = issue_idx_r;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    issue_idx_nxt = issue_idx_r;
    data_idx_nxt  = issue_idx_r;
    data_vld_nxt  = 1'b0;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    free_ok_nxt   = free_ok_r;
    free_idx_nxt  = free_idx_r;
    valid_nxt     = valid_r;
    marked_nxt    = marked_r;
    sweep_vec_nxt = sweep_vec_r;
    out_vld_nxt   = 1'b0;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = hit_idx_r;
    ram_wdata     = {hit_cnt_r, id_r};
    onehot             = '0;
    onehot[data_idx_r] = 1'b1;
    sweep_rest         = sweep_vec_r & ~onehot;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = op_t'(in_opcode);
          id_nxt        = in_id_ext[ID_BITS-1:0];
          issue_idx_nxt = '0;
          hit_nxt       = 1'b0;
          free_ok_nxt   = 1'b0;
          if (op_t'(in_opcode) == OP_SWEEP) begin
            if ((valid_r & marked_r) == '0) begin
              // nothing to reclaim: answer at once
              out_vld_nxt           = 1'b1;
              out_res_nxt.status    = ST_NOTHING;
              out_res_nxt.result_id = '0;
              out_res_nxt.new_count = '0;
              out_res_nxt.last      = 1'b1;
            end else begin
              sweep_vec_nxt = valid_r & marked_r;
              state_nxt     = S_SWEEP;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        data_vld_nxt = 1'b1;
        if (issue_idx_r != LastIdx) begin
          issue_idx_nxt = issue_idx_r + 1'b1;
        end
        if (data_vld_r) begin
          if (valid_r[data_idx_r] && (rd_id == id_r)) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = data_idx_r;
            hit_cnt_nxt  = rd_cnt;
            state_nxt    = S_APPLY;
            data_vld_nxt = 1'b0;
          end else begin
            // remember lowest free slot for add
            if (!valid_r[data_idx_r] && !free_ok_r) begin
              free_ok_nxt  = 1'b1;
              free_idx_nxt = data_idx_r;
            end
            if (data_idx_r == LastIdx) begin
              state_nxt    = S_APPLY;
              data_vld_nxt = 1'b0;
            end
          end
        end
      end

      S_SWEEP: begin
        data_vld_nxt = 1'b1;
        if (issue_idx_r != LastIdx) begin
          issue_idx_nxt = issue_idx_r + 1'b1;
        end
        if (data_vld_r && sweep_vec_r[data_idx_r]) begin
          out_vld_nxt             = 1'b1;
          out_res_nxt.status      = ST_RECLAIMED;
          out_res_nxt.result_id   = id_to_port(rd_id);
          out_res_nxt.new_count   = '0;
          out_res_nxt.last        = (sweep_rest == '0);
          valid_nxt[data_idx_r]   = 1'b0;
          marked_nxt[data_idx_r]  = 1'b0;
          sweep_vec_nxt           = sweep_rest;
          if (sweep_rest == '0) begin
            state_nxt    = S_IDLE;
            data_vld_nxt = 1'b0;
          end
        end
      end

      S_APPLY: begin
        state_nxt             = S_IDLE;
        out_vld_nxt           = 1'b1;
        out_res_nxt.result_id = id_to_port(id_r);
        out_res_nxt.last      = 1'b1;
        out_res_nxt.status    = ST_NOT_FOUND;
        out_res_nxt.new_count = '0;
        case (op_r)
          OP_ADD: begin
            if (hit_r) begin
              out_res_nxt.status    = ST_PRESENT;
              out_res_nxt.new_count = cnt_to_port(hit_cnt_r);
            end else if (free_ok_r) begin
              ram_we                 = 1'b1;
              ram_waddr              = free_idx_r;
              ram_wdata              = {CntOne, id_r};
              valid_nxt[free_idx_r]  = 1'b1;
              marked_nxt[free_idx_r] = 1'b0;
              out_res_nxt.status     = ST_DONE;
              out_res_nxt.new_count  = cnt_to_port(CntOne);
            end else begin
              out_res_nxt.status = ST_FULL;
            end
          end
          OP_INC: begin
            if (hit_r) begin
              if (hit_cnt_r == CntMax) begin
                out_res_nxt.status    = ST_SATURATED;
                out_res_nxt.new_count = cnt_to_port(CntMax);
              end else begin
                ram_we                = 1'b1;
                ram_wdata             = {hit_cnt_r + 1'b1, id_r};
                out_res_nxt.status    = ST_DONE;
                out_res_nxt.new_count = cnt_to_port(hit_cnt_r + 1'b1);
              end
            end
          end
          OP_DEC: begin
            if (hit_r) begin
              if (hit_cnt_r == '0) begin
                out_res_nxt.status = ST_UNDERFLOW;
              end else begin
                ram_we                = 1'b1;
                ram_wdata             = {cnt_dec, id_r};
                out_res_nxt.status    = ST_DONE;
                out_res_nxt.new_count = cnt_to_port(cnt_dec);
                if (cnt_dec == '0) begin
                  marked_nxt[hit_idx_r] = 1'b1;
                end
              end
            end
          end
          default: begin
            out_vld_nxt = 1'b0;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      data_vld_r <= 1'b0;
      valid_r    <= '0;
      marked_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      data_vld_r <= data_vld_nxt;
      valid_r    <= valid_nxt;
      marked_r   <= marked_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    issue_idx_r <= issue_idx_nxt;
    data_idx_r  <= data_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    free_ok_r   <= free_ok_nxt;
    free_idx_r  <= free_idx_nxt;
    sweep_vec_r <= sweep_vec_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_vld_r;
  assign out_res    = out_res_r;

endmodule

// File: rtl/core/refcount_table_lazy_sweep.sv
// ----------------------------------------------------------------------------
// refcount_table_lazy_sweep
// Reference-count table with deleted marks and a lazy sweep that reclaims
// marked entries, one result per reclaimed slot.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start / busy       | in_opcode, in_object_id
//  result   | out_strobe (1 cyc) | out_status, out_result_id, out_new_count,
//           |                    | out_last
//
// Add, increment and decrement keep busy high while ids are compared one slot
// per cycle through the entry RAM read port, up to the slot that holds the id
// or over every slot on a miss, and then while the hit entry is updated. A
// sweep scans the slots up to the last marked one and emits one result per
// reclaimed slot; a sweep with nothing marked answers in the next cycle without raising busy.
// Reset (synchronous, rst_n low) clears the sequencer and the valid and mark
// flags; RAM contents are left as they are. Results cannot be stalled.
// ----------------------------------------------------------------------------
module refcount_table_lazy_sweep
  import rct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned ID_BITS       = ID_BITS_DEF,
  parameter int unsigned COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [ID_PORT_W-1:0]  in_object_id,
  output logic                  out_strobe,
  output logic [2:0]            out_status,
  output logic [ID_PORT_W-1:0]  out_result_id,
  output logic [CNT_PORT_W-1:0] out_new_count,
  output logic                  out_last
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned EntW = ID_BITS + COUNT_BITS;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [EntW-1:0] ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [EntW-1:0] ram_rdata;
  result_t         res;

  // entry store: {count, id} per slot
  rct_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scan / update sequencer
  rct_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ID_BITS       (ID_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_opcode    (in_opcode),
    .in_object_id (in_object_id),
    .busy         (busy),
    .out_strobe   (out_strobe),
    .out_res      (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  // result fields
  assign out_status    = res.status;
  assign out_result_id = res.result_id;
  assign out_new_count = res.new_count;
  assign out_last      = res.last;

endmodule

// File: rtl/core/rct_checker.sv
// ----------------------------------------------------------------------------
// rct_checker
// Port-level checks of the refcount table, bound to the top level.
// ----------------------------------------------------------------------------
`include "refcount_table_lazy_sweep_assert.svh"

module rct_checker
  import rct_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [1:0]            in_opcode,
  input logic                  out_strobe,
  input logic [2:0]            out_status,
  input logic [ID_PORT_W-1:0]  out_result_id,
  input logic [CNT_PORT_W-1:0] out_new_count,
  input logic                  out_last
);

  logic accept;
  logic accept_tbl;
  logic more_ok;
  logic zero_cnt_st;
  logic nothing_ok;

  assign accept     = start && !busy;
  assign accept_tbl = accept && (in_opcode != OP_SWEEP);
  assign more_ok    = busy && (out_status == ST_RECLAIMED);
  assign nothing_ok = out_last && (out_result_id == '0);

  // statuses that always carry a zero count
  assign zero_cnt_st = (out_status == ST_NOT_FOUND) || (out_status == ST_FULL) ||
                       (out_status == ST_UNDERFLOW) || (out_status == ST_RECLAIMED) ||
                       (out_status == ST_NOTHING);

  // an accepted transaction either starts work or answers at once
  `RCT_ASSERT_NXT(a_accept_acts, accept, busy || out_strobe, "accept left block idle")

  // table operations never answer in the cycle after accept
  `RCT_ASSERT_NXT(a_no_early_result, accept_tbl, !out_strobe, "early result")

  // a non-final result means more sweep work is pending
  `RCT_ASSERT_IMP(a_more_follow, out_strobe && !out_last, more_ok, "non-final result while idle")

  // not-found, full, underflow and sweep results carry a zero count
  `RCT_ASSERT_IMP(a_zero_count, out_strobe && zero_cnt_st, out_new_count == '0, "nonzero count")

  // nothing-reclaimed stands alone with a zero id
  `RCT_ASSERT_IMP(a_nothing_alone, out_strobe && (out_status == ST_NOTHING), nothing_ok, "bad nothing result")

endmodule

bind refcount_table_lazy_sweep rct_checker u_rct_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Refcount table with lazy sweep: self-checking testbench
// Drives add / increment / decrement / sweep commands through the start/busy
// handshake and checks every result transaction against an in-bench model of
// the table. The run covers a directed table, a fill and sweep burst, and
// random phases with and without sender idling.
// ----------------------------------------------------------------------------
module testbench;
  import rct_pkg::*;

  localparam int unsigned ENTRIES  = TABLE_ENTRIES_DEF;
  localparam int unsigned POOL_IDS = 24;
  localparam int unsigned DIR_CMDS = 15;
  localparam int unsigned RAND_PER_PHASE = 50;
  localparam logic [CNT_PORT_W-1:0] COUNT_TOP = {CNT_PORT_W{1'b1}};
  localparam logic [ID_PORT_W-1:0]  SAT_ID    = 16'hC3C3;

  // one row of the directed command table
  typedef struct {
    op_t                   op;
    logic [ID_PORT_W-1:0]  id;
    bit                    typed;
    status_t               st;
    logic [CNT_PORT_W-1:0] cnt;
  } cmd_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  op_t                   in_opcode = OP_ADD;
  logic [ID_PORT_W-1:0]  in_object_id = '0;
  logic                  out_strobe;
  logic [2:0]            out_status;
  logic [ID_PORT_W-1:0]  out_result_id;
  logic [CNT_PORT_W-1:0] out_new_count;
  logic                  out_last;

  // table model
  bit                    tbl_valid  [ENTRIES];
  logic [ID_PORT_W-1:0]  tbl_id     [ENTRIES];
  logic [CNT_PORT_W-1:0] tbl_count  [ENTRIES];
  bit                    tbl_marked [ENTRIES];

  result_t               pending_results [$];
  result_t               step_results [$];
  cmd_row_t              directed_cmds [DIR_CMDS];
  logic [ID_PORT_W-1:0]  id_pool [POOL_IDS];
  int unsigned           mismatch_count = 0;

  refcount_table_lazy_sweep dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_object_id  (in_object_id),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_result_id (out_result_id),
    .out_new_count (out_new_count),
    .out_last      (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // apply one command to the table model, results land in step_results
  task automatic table_update(input op_t op, input logic [ID_PORT_W-1:0] id);
    int slot;
    int free_slot;
    step_results.delete();
    if (op == OP_SWEEP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_marked[i]) begin
          step_results.push_back('{ST_RECLAIMED, tbl_id[i], '0, 1'b0});
          tbl_valid[i]  = 1'b0;
          tbl_marked[i] = 1'b0;
        end
      end
      if (step_results.size() == 0)
        step_results.push_back('{ST_NOTHING, '0, '0, 1'b1});
      else
        step_results[step_results.size()-1].last = 1'b1;
    end else begin
      slot = -1;
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && tbl_valid[i] && tbl_id[i] == id)
          slot = i;
        if (free_slot < 0 && !tbl_valid[i])
          free_slot = i;
      end
      if (op == OP_ADD) begin
        if (slot >= 0) begin
          step_results.push_back('{ST_PRESENT, id, tbl_count[slot], 1'b1});
        end else if (free_slot >= 0) begin
          tbl_valid[free_slot]  = 1'b1;
          tbl_id[free_slot]     = id;
          tbl_count[free_slot]  = 16'd1;
          tbl_marked[free_slot] = 1'b0;
          step_results.push_back('{ST_DONE, id, 16'd1, 1'b1});
        end else begin
          step_results.push_back('{ST_FULL, id, '0, 1'b1});
        end
      end else if (slot < 0) begin
        step_results.push_back('{ST_NOT_FOUND, id, '0, 1'b1});
      end else if (op == OP_INC) begin
        // saturate at the top, mark untouched
        if (tbl_count[slot] == COUNT_TOP) begin
          step_results.push_back('{ST_SATURATED, id, COUNT_TOP, 1'b1});
        end else begin
          tbl_count[slot] = tbl_count[slot] + 1'b1;
          step_results.push_back('{ST_DONE, id, tbl_count[slot], 1'b1});
        end
      end else begin
        // decrement: refuse at zero, mark on reaching zero
        if (tbl_count[slot] == '0) begin
          step_results.push_back('{ST_UNDERFLOW, id, '0, 1'b1});
        end else begin
          tbl_count[slot] = tbl_count[slot] - 1'b1;
          if (tbl_count[slot] == '0)
            tbl_marked[slot] = 1'b1;
          step_results.push_back('{ST_DONE, id, tbl_count[slot], 1'b1});
        end
      end
    end
  endtask

  // drive one command and hold it until accepted; returns at the accepting edge
  task automatic send_command(input op_t op, input logic [ID_PORT_W-1:0] id,
                              input bit typed, input result_t typed_res);
    start        <= 1'b1;
    in_opcode    <= op;
    in_object_id <= id;
    do @(posedge clk); while (busy !== 1'b0);
    table_update(op, id);
    if (typed)
      pending_results.push_back(typed_res);
    else
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  // random idle cycles after an accepted transaction
  task automatic sender_pause(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // stop sending until every expected result is back, then settle
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
  endtask

  function automatic void check_field(input string name,
                                      input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t exp_res;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d id %0h count %0h", $time,
                 out_status, out_result_id, out_new_count);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", 16'(exp_res.status), 16'(out_status));
        check_field("result_id", exp_res.result_id, out_result_id);
        check_field("new_count", exp_res.new_count, out_new_count);
        check_field("last", 16'(exp_res.last), 16'(out_last));
      end
    end
  end

  // stimulus
  initial begin
    int unsigned idle_pct [4];
    int unsigned pick;
    op_t op;
    logic [ID_PORT_W-1:0] id;
    result_t typed_res;

    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_marked[i] = 1'b0;
      tbl_id[i]     = '0;
      tbl_count[i]  = '0;
    end

    // directed table: typed rows have results that are obvious at a glance
    directed_cmds[0]  = '{OP_SWEEP, 16'h0000, 1'b1, ST_NOTHING,   16'd0};
    directed_cmds[1]  = '{OP_INC,   16'h1234, 1'b1, ST_NOT_FOUND, 16'd0};
    directed_cmds[2]  = '{OP_DEC,   16'hFFFF, 1'b1, ST_NOT_FOUND, 16'd0};
    directed_cmds[3]  = '{OP_ADD,   16'h0000, 1'b1, ST_DONE,      16'd1};
    directed_cmds[4]  = '{OP_ADD,   16'hFFFF, 1'b1, ST_DONE,      16'd1};
    directed_cmds[5]  = '{OP_ADD,   16'h0000, 1'b1, ST_PRESENT,   16'd1};
    directed_cmds[6]  = '{OP_INC,   16'hFFFF, 1'b1, ST_DONE,      16'd2};
    directed_cmds[7]  = '{OP_DEC,   16'h0000, 1'b1, ST_DONE,      16'd0};
    directed_cmds[8]  = '{OP_DEC,   16'h0000, 1'b1, ST_UNDERFLOW, 16'd0};
    // marked but unswept id still counts as present
    directed_cmds[9]  = '{OP_ADD,   16'h0000, 1'b1, ST_PRESENT,   16'd0};
    // increment of a marked entry keeps the mark
    directed_cmds[10] = '{OP_INC,   16'h0000, 1'b0, ST_DONE,      16'd0};
    directed_cmds[11] = '{OP_DEC,   16'hFFFF, 1'b0, ST_DONE,      16'd0};
    directed_cmds[12] = '{OP_DEC,   16'hFFFF, 1'b0, ST_DONE,      16'd0};
    // sweep ignores its id field
    directed_cmds[13] = '{OP_SWEEP, 16'hABCD, 1'b0, ST_DONE,      16'd0};
    directed_cmds[14] = '{OP_SWEEP, 16'h0000, 1'b1, ST_NOTHING,   16'd0};

    id_pool[0] = SAT_ID;
    for (int i = 1; i < POOL_IDS; i++)
      id_pool[i] = 16'($urandom_range(65535));

    idle_pct[0] = 0;
    idle_pct[1] = 68;
    idle_pct[2] = 0;
    idle_pct[3] = 34;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed commands, back to back
    for (int k = 0; k < DIR_CMDS; k++) begin
      typed_res = '{directed_cmds[k].st, directed_cmds[k].id, directed_cmds[k].cnt, 1'b1};
      send_command(directed_cmds[k].op, directed_cmds[k].id, directed_cmds[k].typed,
                   typed_res);
    end

    // fill the table, overflow it, mark every entry and sweep them all
    for (int k = 0; k <= ENTRIES; k++)
      send_command(OP_ADD, 16'h1000 + 16'(k) * 16'h0111, 1'b0, '0);
    for (int k = 0; k < ENTRIES; k++)
      send_command(OP_DEC, 16'h1000 + 16'(k) * 16'h0111, 1'b0, '0);
    send_command(OP_SWEEP, 16'h0000, 1'b0, '0);
    drain_results();

    // random phases, each closed by a full drain
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 35)      op = OP_ADD;
        else if (pick < 55) op = OP_INC;
        else if (pick < 90) op = OP_DEC;
        else                op = OP_SWEEP;
        if ($urandom_range(99) < 85)
          id = id_pool[$urandom_range(POOL_IDS - 1)];
        else
          id = 16'($urandom_range(65535));
        send_command(op, id, 1'b0, '0);
        sender_pause(idle_pct[ph]);
      end
      drain_results();
    end

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
